// ----- sv/fsmn_pkg.sv -----
// ----------------------------------------------------------------------------
// fsmn_pkg: shared types and constants of the depthwise memory filter
// Widths, payload structs, control/status bundles and register codes.
// ----------------------------------------------------------------------------
package fsmn_pkg;

    // storage sizing
    localparam int MAX_CHANNELS = 512;
    localparam int MAX_TAPS     = 16;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int TAP_W        = $clog2(MAX_TAPS);
    localparam int ADDR_W       = CH_W + TAP_W;
    localparam int FRAMES_W     = $clog2(MAX_TAPS + 1);

    // configuration register widths and codes
    localparam int CHANS_CFG_W  = 10;
    localparam int TAPS_CFG_W   = 5;
    localparam int CTR_CFG_W    = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 2'd2;

    // item kinds
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // arithmetic
    localparam int COEF_W  = 17;
    localparam int PROD_W  = 33;
    localparam int ACC_W   = 40;
    localparam int FRAC_SH = 14;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] value;
        logic [8:0]         weight_channel;
        logic [3:0]         weight_tap;
        logic               sequence_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic [8:0]         out_channel;
        logic               frame_last;
        logic               saturated;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic             take_weight;
        logic             take_sample;
        logic             rd_en;
        logic [TAP_W-1:0] rd_tap;
        logic             mul_en;
        logic             acc_en;
        logic             out_load;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic             mac_needed;
        logic [TAP_W-1:0] last_tap;
        logic             out_free;
    } t_dp_sts;

endpackage

// ----- sv/fsmn_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsmn_ctrl: sequencer of the memory filter
// Accepts items, steps the tap counter and tracks the read/multiply pipe.
// ----------------------------------------------------------------------------
module fsmn_ctrl
    import fsmn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_kind,
    output logic     o_in_stall,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [TAP_W-1:0] r_k, n_k;
    logic             r_iss_vld;
    logic             r_mul_vld;
    logic             take;

    assign o_in_stall = (r_state != S_IDLE);
    assign take       = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd             = '0;
        o_cmd.take_weight = take && (i_in_kind == KIND_WEIGHT);
        o_cmd.take_sample = take && (i_in_kind == KIND_SAMPLE);
        o_cmd.rd_en       = (r_state == S_RUN);
        o_cmd.rd_tap      = r_k;
        o_cmd.mul_en      = r_iss_vld;
        o_cmd.acc_en      = r_mul_vld;
        o_cmd.out_load    = (r_state == S_OUT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.take_sample && i_sts.mac_needed) begin
                    n_state = S_RUN;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (r_k == i_sts.last_tap) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!r_iss_vld && !r_mul_vld) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_iss_vld <= 1'b0;
            r_mul_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_iss_vld <= o_cmd.rd_en;
            r_mul_vld <= r_iss_vld;
        end
    end

    // product stage only fills from a read issued the cycle before
    a_mul_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_vld |-> $past(r_iss_vld))
        else $error("multiply stage valid without a preceding read");

    // the result is taken only from a fully drained accumulator
    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (!r_iss_vld && !r_mul_vld))
        else $error("result stage entered with taps still in flight");

    // tap counter stays within the configured kernel
    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= i_sts.last_tap))
        else $error("tap counter ran past the kernel length");

endmodule

// ----- sv/fsmn_dpath.sv -----
// ----------------------------------------------------------------------------
// fsmn_dpath: storage and arithmetic of the memory filter
// Config registers, frame counters, weight and history memories, MAC and
// the rounding/saturating output register.
// ----------------------------------------------------------------------------
module fsmn_dpath
    import fsmn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_in_item              i_in_data,
    input  t_ctl_cmd              i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1 << (FRAC_SH - 1));
    localparam logic signed [ACC_W-1:0]  SAT_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0]  SAT_LO   = -ACC_W'(32768);
    localparam logic signed [COEF_W-1:0] UNITY    = COEF_W'(1 << FRAC_SH);

    // configuration
    logic [CHANS_CFG_W-1:0] r_chans;
    logic [TAPS_CFG_W-1:0]  r_taps;
    logic [CTR_CFG_W-1:0]   r_center;

    logic [CHANS_CFG_W-1:0] chans_eff;
    logic [TAPS_CFG_W-1:0]  taps_eff;
    logic [TAP_W-1:0]       tap_max;
    logic [TAP_W-1:0]       center_eff;
    logic [TAP_W-1:0]       look;

    // sequence counters
    logic [CH_W-1:0]     r_pos;
    logic [TAP_W-1:0]    r_head;
    logic [FRAMES_W-1:0] r_frames;

    // item being filtered
    logic [CH_W-1:0]     r_ch;
    logic [TAP_W-1:0]    r_cur_head;
    logic [FRAMES_W-1:0] r_cur_f;
    logic                r_last;

    logic [CH_W-1:0]        pos;
    logic [TAP_W-1:0]       head;
    logic [FRAMES_W-1:0]    f;
    logic [CH_W-1:0]        ch;
    logic [CHANS_CFG_W-1:0] chans_m1;
    logic                   last;

    // memories
    logic signed [15:0] r_wmem [MAX_CHANNELS*MAX_TAPS];
    logic signed [15:0] r_hmem [MAX_CHANNELS*MAX_TAPS];
    logic signed [15:0] r_w_q;
    logic signed [15:0] r_h_q;
    logic               w_wr;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  h_waddr;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ADDR_W-1:0]  h_raddr;
    logic [TAP_W-1:0]   tap_lag;
    logic [TAP_W-1:0]   slot;

    // mac pipe
    logic                     r_rd_use;
    logic                     r_rd_ctr;
    logic signed [COEF_W-1:0] coef;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // rounding
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] rq;
    logic                    sat_hi;
    logic                    sat_lo;

    logic      r_out_vld;
    t_out_item r_out;
    logic      out_take;

    // effective register values
    always_comb begin
        if (r_chans == '0) begin
            chans_eff = CHANS_CFG_W'(1);
        end else if (r_chans > CHANS_CFG_W'(MAX_CHANNELS)) begin
            chans_eff = CHANS_CFG_W'(MAX_CHANNELS);
        end else begin
            chans_eff = r_chans;
        end
        if (r_taps == '0) begin
            taps_eff = TAPS_CFG_W'(1);
        end else if (r_taps > TAPS_CFG_W'(MAX_TAPS)) begin
            taps_eff = TAPS_CFG_W'(MAX_TAPS);
        end else begin
            taps_eff = r_taps;
        end
        tap_max = TAP_W'(taps_eff - 1'b1);
        if (TAP_W'(r_center) > tap_max) begin
            center_eff = tap_max;
        end else begin
            center_eff = TAP_W'(r_center);
        end
        look = tap_max - center_eff;
    end

    // position of an incoming sample
    always_comb begin
        pos      = i_in_data.sequence_start ? '0 : r_pos;
        head     = i_in_data.sequence_start ? '0 : r_head;
        f        = i_in_data.sequence_start ? '0 : r_frames;
        chans_m1 = chans_eff - 1'b1;
        if (CHANS_CFG_W'(pos) >= chans_eff) begin
            ch = chans_m1[CH_W-1:0];
        end else begin
            ch = pos;
        end
        last = (CHANS_CFG_W'(pos) + 1'b1) >= chans_eff;
    end

    assign o_sts.mac_needed = (f >= FRAMES_W'(look));
    assign o_sts.last_tap   = tap_max;
    assign o_sts.out_free   = !r_out_vld || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans  <= CHANS_CFG_W'(512);
            r_taps   <= TAPS_CFG_W'(11);
            r_center <= CTR_CFG_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS: r_chans  <= i_cfg_wdata[CHANS_CFG_W-1:0];
                CFG_TAPS:     r_taps   <= i_cfg_wdata[TAPS_CFG_W-1:0];
                CFG_CENTER:   r_center <= i_cfg_wdata[CTR_CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_head   <= '0;
            r_frames <= '0;
        end else if (i_cmd.take_sample) begin
            if (last) begin
                r_pos  <= '0;
                r_head <= head + 1'b1;
                if (f < FRAMES_W'(MAX_TAPS)) begin
                    r_frames <= f + 1'b1;
                end else begin
                    r_frames <= f;
                end
            end else begin
                r_pos    <= ch + 1'b1;
                r_head   <= head;
                r_frames <= f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_ch       <= ch;
            r_cur_head <= head;
            r_cur_f    <= f;
            r_last     <= last;
        end
    end

    // memory addressing
    assign w_wr    = i_cmd.take_weight
                     && (int'(i_in_data.weight_channel) < MAX_CHANNELS)
                     && (int'(i_in_data.weight_tap) < MAX_TAPS);
    assign w_waddr = {CH_W'(i_in_data.weight_channel), TAP_W'(i_in_data.weight_tap)};
    assign h_waddr = {ch, head};
    assign tap_lag = tap_max - i_cmd.rd_tap;
    assign slot    = r_cur_head - tap_lag;
    assign w_raddr = {r_ch, i_cmd.rd_tap};
    assign h_raddr = {r_ch, slot};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_wmem[w_waddr] <= i_in_data.value;
        end
        if (i_cmd.rd_en) begin
            r_w_q <= r_wmem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_hmem[h_waddr] <= i_in_data.value;
        end
        if (i_cmd.rd_en) begin
            r_h_q <= r_hmem[h_raddr];
        end
    end

    // taps reaching before the sequence start count as zero;
    // the center tap also carries the residual
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_use <= (FRAMES_W'(tap_lag) <= r_cur_f);
            r_rd_ctr <= (i_cmd.rd_tap == center_eff);
        end
    end

    assign coef = COEF_W'(r_w_q) + (r_rd_ctr ? UNITY : '0);
    assign prod = coef * r_h_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_rd_use ? prod : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up to Q4.12 and clip
    assign biased = r_acc + RND_HALF;
    assign rq     = biased >>> FRAC_SH;
    assign sat_hi = (rq > SAT_HI);
    assign sat_lo = (rq < SAT_LO);

    assign out_take = r_out_vld && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (sat_hi) begin
                r_out.filtered <= 16'sh7fff;
            end else if (sat_lo) begin
                r_out.filtered <= 16'sh8000;
            end else begin
                r_out.filtered <= rq[15:0];
            end
            r_out.out_channel <= 9'(r_ch);
            r_out.frame_last  <= r_last;
            r_out.saturated   <= sat_hi || sat_lo;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a clipped result sits at one of the rails
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.saturated)
            |-> (r_out.filtered == 16'sh7fff || r_out.filtered == 16'sh8000))
        else $error("saturated result not at a rail");

    // frame count saturates at the ring depth
    a_frames_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= FRAMES_W'(MAX_TAPS))
        else $error("frame count past ring depth");

    // the output register is never overwritten while a beat waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_out_vld) |-> !i_out_stall)
        else $error("pending result overwritten");

endmodule

// ----- sv/fsmn_depthwise_memory_filter_top.sv -----
// ----------------------------------------------------------------------------
// fsmn_depthwise_memory_filter_top: depthwise FIR memory filter with residual
// Per-channel FIR over time plus the center-tap sample, Q4.12 out, saturated.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle on the input side only when idle. A
// weight beat (kind 0) writes one entry of the per-channel tap table. A
// sample beat (kind 1) is written to that channel's ring of past frames; if
// the lookahead is not yet filled it gives no result and the block is idle
// again at once. Otherwise the filter walks the taps (11 by default) one per
// cycle through the single shared multiplier, which reads one weight and one
// history entry a cycle from the two memories; after the last tap read the
// pipe drains through the product and accumulate stages, the sequencer checks
// that it is empty, and the rounded result is loaded into the output register.
// The next beat is accepted only after that load. A result waiting in the
// output register does not hold up the next input beat; only the load of the
// next result waits for it to drain, which adds the receiver's stall to that
// sample. Samples older than the sequence start read as zero. The tap table
// and history memories have no reset; channels and taps must be written
// before they are used.
// ----------------------------------------------------------------------------
module fsmn_depthwise_memory_filter_top
    import fsmn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    // sequencer: accept, tap stepping, pipe tracking
    fsmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // memories, counters, mac and output register
    fsmn_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
